[design/crc_fr_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// crc_fr_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the framed
// UART receiver.
// -----------------------------------------------------------------------------
package crc_fr_pkg;

  // Default receive buffer depth in bytes.
  localparam int BUFFER_DEPTH_DEF = 64;

  // Fixed frame constants.
  localparam logic [7:0]  STATUS_CMD      = 8'h03;
  localparam int          RECORD_LEN      = 9;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] IDLE_TICKS_RST  = 16'd50;
  localparam logic [7:0]  HEADER_RST      = 8'h5A;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic [0:0] {
    REG_IDLE_TIMEOUT = 1'b0,
    REG_HEADER       = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] idle_timeout_ticks;
    logic [7:0]  header_byte;
  } cfg_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_FRAME_OK = 3'd1,
    EV_STATUS   = 3'd2,
    EV_CRC_ERR  = 3'd3,
    EV_HDR_ERR  = 3'd4,
    EV_OVERFLOW = 3'd5,
    EV_TIMEOUT  = 3'd6
  } ev_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    ev_t        event_res;
    logic [7:0] frame_command;
    logic [7:0] fw_rev;
    logic [7:0] board_rev;
    logic [7:0] link_status;
    logic [7:0] pulse_bpm;
    logic [7:0] resp_bpm;
    logic [7:0] diastolic_pressure;
    logic [7:0] systolic_pressure;
    logic [7:0] rest_index;
    logic [7:0] off_bed;
  } out_item_t;

  // One byte through the reflected CRC-16/MODBUS register.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[design/crc_fr_regs.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// crc_fr_regs
// APB-style configuration registers: idle timeout and header byte.
// -----------------------------------------------------------------------------
module crc_fr_regs
  import crc_fr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_timeout_ticks <= IDLE_TICKS_RST;
      cfg_r.header_byte        <= HEADER_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_IDLE_TIMEOUT: cfg_r.idle_timeout_ticks <= cfg_pwdata[15:0];
        REG_HEADER:       cfg_r.header_byte        <= cfg_pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IDLE_TIMEOUT: cfg_prdata = {16'h0000, cfg_r.idle_timeout_ticks};
      REG_HEADER:       cfg_prdata = {24'h000000, cfg_r.header_byte};
    endcase
  end

endmodule

[design/crc_fr_frame.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// crc_fr_frame
// Frame state and the single-pass update for one byte or tick beat.
// -----------------------------------------------------------------------------
module crc_fr_frame
  import crc_fr_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int EXT_W = ((CNT_W > 9) ? CNT_W : 9) + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [15:0]      idle_r,  idle_nxt;
  logic [15:0]      crc_r,   crc_nxt;
  logic [7:0]       dly0_r,  dly0_nxt;
  logic [7:0]       dly1_r,  dly1_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       cmd_r,   cmd_nxt;
  logic [7:0]       len_r,   len_nxt;
  logic [7:0]       shadow_r [RECORD_LEN];
  logic [7:0]       shadow_nxt [RECORD_LEN];
  logic [7:0]       status_r [RECORD_LEN];
  logic [7:0]       status_nxt [RECORD_LEN];

  logic [EXT_W-1:0] pos_ext;
  logic [EXT_W-1:0] cnt_ext;
  logic [EXT_W-1:0] rec_off;
  logic [EXT_W-1:0] frame_len;
  logic [15:0]      crc_fed;
  logic             clear;
  logic             latch;
  ev_t              ev;
  logic [7:0]       cmd_out;

  assign pos_ext   = EXT_W'(cnt_r);
  assign cnt_ext   = EXT_W'(cnt_nxt);
  assign rec_off   = pos_ext - EXT_W'(3);
  assign frame_len = EXT_W'(len_nxt) + EXT_W'(5);
  assign crc_fed   = crc16_byte(crc_r, dly0_r);

  always_comb begin
    cnt_nxt   = cnt_r;
    idle_nxt  = idle_r;
    crc_nxt   = crc_r;
    dly0_nxt  = dly0_r;
    dly1_nxt  = dly1_r;
    first_nxt = first_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    for (int i = 0; i < RECORD_LEN; i++) begin
      shadow_nxt[i] = shadow_r[i];
      status_nxt[i] = status_r[i];
    end
    clear   = 1'b0;
    latch   = 1'b0;
    ev      = EV_NONE;
    cmd_out = 8'h00;

    priority if (item.func) begin
      // Tick: count down only while a partial frame is held.
      if (idle_r != 16'd0 && cnt_r != '0) begin
        idle_nxt = idle_r - 16'd1;
        if (idle_r == 16'd1) begin
          clear = 1'b1;
          ev    = EV_TIMEOUT;
        end
      end
    end else if (cnt_r >= DEPTH_C) begin
      clear = 1'b1;
      ev    = EV_OVERFLOW;
    end else begin
      cnt_nxt  = cnt_r + CNT_W'(1);
      idle_nxt = cfg.idle_timeout_ticks;
      // The two newest bytes wait in the delay line; feed the older one.
      if (pos_ext >= EXT_W'(2)) begin
        crc_nxt = crc_fed;
      end
      dly0_nxt = dly1_r;
      dly1_nxt = item.rx_byte;

      priority if (pos_ext == EXT_W'(0)) begin
        first_nxt = item.rx_byte;
      end else if (pos_ext == EXT_W'(1)) begin
        cmd_nxt = item.rx_byte;
      end else if (pos_ext == EXT_W'(2)) begin
        len_nxt = item.rx_byte;
      end else if (rec_off < EXT_W'(RECORD_LEN) && rec_off < EXT_W'(len_r)) begin
        for (int i = 0; i < RECORD_LEN; i++) begin
          if (rec_off == EXT_W'(i)) begin
            shadow_nxt[i] = item.rx_byte;
          end
        end
      end else begin
        // Trailing bytes past the payload only move through the delay line.
      end

      if (cnt_ext > EXT_W'(3)) begin
        priority if (first_nxt != cfg.header_byte) begin
          clear = 1'b1;
          ev    = EV_HDR_ERR;
        end else if (frame_len <= cnt_ext) begin
          cmd_out = cmd_nxt;
          clear   = 1'b1;
          if ({dly1_nxt, dly0_nxt} == crc_nxt) begin
            ev = EV_FRAME_OK;
            if (cmd_nxt == STATUS_CMD && len_nxt <= 8'(RECORD_LEN)) begin
              latch = 1'b1;
              ev    = EV_STATUS;
            end
          end else begin
            ev = EV_CRC_ERR;
          end
        end else begin
          // Still collecting.
        end
      end
    end

    if (latch) begin
      for (int i = 0; i < RECORD_LEN; i++) begin
        status_nxt[i] = shadow_nxt[i];
      end
    end

    if (clear) begin
      cnt_nxt   = '0;
      crc_nxt   = CRC_INIT;
      dly0_nxt  = 8'h00;
      dly1_nxt  = 8'h00;
      first_nxt = 8'h00;
      cmd_nxt   = 8'h00;
      len_nxt   = 8'h00;
      for (int i = 0; i < RECORD_LEN; i++) begin
        shadow_nxt[i] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      idle_r  <= 16'd0;
      crc_r   <= CRC_INIT;
      dly0_r  <= 8'h00;
      dly1_r  <= 8'h00;
      first_r <= 8'h00;
      cmd_r   <= 8'h00;
      len_r   <= 8'h00;
      for (int i = 0; i < RECORD_LEN; i++) begin
        shadow_r[i] <= 8'h00;
        status_r[i] <= 8'h00;
      end
    end else if (step) begin
      cnt_r   <= cnt_nxt;
      idle_r  <= idle_nxt;
      crc_r   <= crc_nxt;
      dly0_r  <= dly0_nxt;
      dly1_r  <= dly1_nxt;
      first_r <= first_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      for (int i = 0; i < RECORD_LEN; i++) begin
        shadow_r[i] <= shadow_nxt[i];
        status_r[i] <= status_nxt[i];
      end
    end
  end

  assign result.event_res          = ev;
  assign result.frame_command      = cmd_out;
  assign result.fw_rev             = status_nxt[0];
  assign result.board_rev          = status_nxt[1];
  assign result.link_status        = status_nxt[2];
  assign result.pulse_bpm          = status_nxt[3];
  assign result.resp_bpm           = status_nxt[4];
  assign result.diastolic_pressure = status_nxt[5];
  assign result.systolic_pressure  = status_nxt[6];
  assign result.rest_index         = status_nxt[7];
  assign result.off_bed            = status_nxt[8];

endmodule

[design/crc_framed_uart_receiver.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// crc_framed_uart_receiver
// Framed UART receiver with CRC-16/MODBUS check and status record latch.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): each beat is either a
//   received UART byte (func = 0) or a one millisecond tick (func = 1).
//   Result channel (out_valid / out_stall / out_data): exactly one result
//   beat per input beat, in order, carrying the event code, the command of a
//   completed frame and the nine bytes of the latched status record.
//   Config port (cfg_*): APB-style, idle timeout at 0x0, header byte at 0x4;
//   write only while no beats are in flight.
// Timing:
//   A beat is registered on acceptance, runs through the CRC byte update and
//   frame checks, and lands in the result register that drives out_valid and
//   out_data. One beat can be accepted every cycle while out_stall is low;
//   the byte-wide CRC update (eight shift steps) is the longest path between
//   the input and result registers.
// Reset: rst_n (synchronous, active low) empties both pipeline registers,
//   drops any partial frame, zeroes the status record and reloads the config
//   defaults (timeout 50 ticks, header 0x5A).
// Back-pressure: while out_stall is high a held result stays put; the input
//   register keeps taking a beat until it also fills, then in_stall rises.
// -----------------------------------------------------------------------------
module crc_framed_uart_receiver
  import crc_fr_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input beats
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // Result beats
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // Configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t      cfg;
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      advance;
  logic      in_take;

  crc_fr_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // Advance the held beat when the result register is free or being drained.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  crc_fr_frame #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .result(result)
  );

  // Input register: load on acceptance, drop once the beat has advanced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  // Result register: hold while stalled, clear valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
